### src/mcd_pkg.sv
package mcd_pkg;

    // Field widths
    localparam int MICROS_W = 64;
    localparam int YEAR_W   = 20;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int USEC_W   = 20;

    // Day split: microseconds per day = 2^13 * 10546875.
    // Low 13 bits pass around the divider, the rest is biased to be
    // non-negative and divided by 10546875 with a reciprocal multiply
    // cut into 26-bit halves.
    localparam int LO_W      = 13;
    localparam int U_W       = MICROS_W - LO_W + 1;     // biased dividend
    localparam int QUOT_W    = 29;                      // biased day number
    localparam int REM_W     = 24;
    localparam int TOD_W     = REM_W + LO_W;            // microseconds of day
    localparam logic [REM_W-1:0] DAY_DIV = 24'd10546875;
    localparam longint unsigned DAY_BIAS = 64'd1 << 27;
    localparam logic [U_W-1:0] U_BIAS = U_W'(DAY_BIAS * 64'd10546875);
    localparam int HALF_W    = 26;
    localparam int PP_W      = 2 * HALF_W;              // one partial product
    localparam int TOP_W     = PP_W + HALF_W;           // product bits above the low half
    localparam int DAY_K     = 75;
    localparam int DAY_M_W   = 52;
    localparam logic [DAY_M_W-1:0] DAY_M =
        DAY_M_W'(((128'd1 << DAY_K) + 128'(DAY_DIV) - 128'd1) / 128'(DAY_DIV));

    // Civil date
    localparam int ZP_W     = 28;
    localparam int ERA_Q_W  = 11;
    localparam int DE_W     = 18;
    localparam int QA_W     = 8;
    localparam int QB_W     = 3;
    localparam int YE_W     = 9;
    localparam int C100_W   = 2;
    localparam int DY_W     = 9;
    localparam int X5_W     = 11;
    localparam int MP_W     = 4;
    localparam logic [DE_W-1:0] ERA_DAYS = 18'd146097;
    localparam logic [DE_W-1:0] DE_LAST  = 18'd146096;
    localparam logic [DE_W-1:0] YEAR_DAYS = 18'd365;
    localparam longint unsigned ERA_BIAS = 64'd1024;
    // day count from 0000-03-01, plus era bias, minus the divider bias
    localparam logic [ZP_W-1:0] ZP_BIAS =
        ZP_W'(64'd719468 + ERA_BIAS * 64'd146097 - DAY_BIAS);
    localparam logic [YE_W-1:0]   ERA_YEARS = 9'd400;
    localparam logic [YEAR_W-1:0] YEAR_BIAS = YEAR_W'(ERA_BIAS * 64'd400);
    localparam logic [MP_W-1:0]   MP_JAN    = 4'd10;

    // Reciprocals: m = ceil(2^k / d), exact over the operand range
    localparam int ERA_K   = 46;
    localparam int ERA_M_W = 29;
    localparam logic [ERA_M_W-1:0] ERA_M =
        ERA_M_W'(((64'd1 << ERA_K) + 64'd146096) / 64'd146097);
    localparam int K1460 = 29;
    localparam logic [18:0] M1460 = 19'(((64'd1 << K1460) + 64'd1459) / 64'd1460);
    localparam int K36524 = 34;
    localparam logic [18:0] M36524 =
        19'(((64'd1 << K36524) + 64'd36523) / 64'd36524);
    localparam int K365 = 27;
    localparam logic [18:0] M365 = 19'(((64'd1 << K365) + 64'd364) / 64'd365);
    localparam int K100 = 16;
    localparam logic [9:0] M100 = 10'(((64'd1 << K100) + 64'd99) / 64'd100);
    localparam int K153 = 19;
    localparam logic [11:0] M153 = 12'(((64'd1 << K153) + 64'd152) / 64'd153);

    // Time of day
    localparam int USEC_SHIFT = 6;                      // 10^6 = 2^6 * 15625
    localparam int SX_W       = TOD_W - USEC_SHIFT;
    localparam int SECS_W     = 17;
    localparam int RS_W       = 12;
    localparam logic [13:0] USEC_DIV  = 14'd15625;
    localparam logic [11:0] HOUR_SECS = 12'd3600;
    localparam logic [5:0]  MIN_SECS  = 6'd60;
    localparam int K15625 = 45;
    localparam logic [31:0] M15625 =
        32'(((64'd1 << K15625) + 64'd15624) / 64'd15625);
    localparam int K3600 = 29;
    localparam logic [17:0] M3600 = 18'(((64'd1 << K3600) + 64'd3599) / 64'd3600);
    localparam int K60 = 18;
    localparam logic [12:0] M60 = 13'(((64'd1 << K60) + 64'd59) / 64'd60);

    // Pipeline depths
    localparam int SPLIT_STAGES = 6;
    localparam int DATE_STAGES  = 10;
    localparam int TIME_STAGES  = 6;
    localparam int TIME_PAD     = DATE_STAGES - TIME_STAGES;
    localparam int PIPE_LAT     = SPLIT_STAGES + DATE_STAGES;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic [TOD_W-1:0]  tod;
    } t_split;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
    } t_date;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [USEC_W-1:0] usec;
    } t_clock;

    // first day of month (March-based) minus one: (153*mp + 2) / 5
    function automatic logic [DY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DY_W-1:0] res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

### src/mcd_day_split.sv
module mcd_day_split (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [mcd_pkg::MICROS_W-1:0]  i_micros,
    output logic                          o_valid,
    output mcd_pkg::t_split               o_split
);
    import mcd_pkg::*;

    logic                r_v [0:SPLIT_STAGES-1];

    logic [U_W-1:0]      r_u_0;
    logic [LO_W-1:0]     r_lo_0, r_lo_1, r_lo_2, r_lo_3, r_lo_4, r_lo_5;
    logic [REM_W-1:0]    r_ul_1, r_ul_2, r_ul_3, r_ul_4;
    logic [PP_W-1:0]     r_pp_hh_1, r_pp_hl_1, r_pp_lh_1, r_pp_ll_1;
    logic [PP_W:0]       r_mid_2;
    logic [TOP_W-1:0]    r_top_2;
    logic [QUOT_W-1:0]   r_q_3, r_q_4, r_q_5;
    logic [REM_W-1:0]    r_qd_4;
    logic [REM_W-1:0]    r_rem_5;

    logic [U_W-1:0]      n_u;
    logic [TOP_W-1:0]    prod_top;
    logic [REM_W-1:0]    qd;

    // floor(t / 2^13), sign-extended, plus bias so the divide is unsigned
    assign n_u = {i_micros[MICROS_W-1], i_micros[MICROS_W-1:LO_W]} + U_BIAS;

    // low half of the product carries nothing into the upper bits
    assign prod_top = r_top_2 + TOP_W'(r_mid_2);
    // quotient is exact, so the remainder fits in its low bits
    assign qd       = r_q_3[REM_W-1:0] * DAY_DIV;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SPLIT_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < SPLIT_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u_0     <= n_u;
        r_lo_0    <= i_micros[LO_W-1:0];

        r_pp_hh_1 <= PP_W'(r_u_0[U_W-1:HALF_W]) * PP_W'(DAY_M[DAY_M_W-1:HALF_W]);
        r_pp_hl_1 <= PP_W'(r_u_0[U_W-1:HALF_W]) * PP_W'(DAY_M[HALF_W-1:0]);
        r_pp_lh_1 <= PP_W'(r_u_0[HALF_W-1:0]) * PP_W'(DAY_M[DAY_M_W-1:HALF_W]);
        r_pp_ll_1 <= PP_W'(r_u_0[HALF_W-1:0]) * PP_W'(DAY_M[HALF_W-1:0]);
        r_ul_1    <= r_u_0[REM_W-1:0];
        r_lo_1    <= r_lo_0;

        r_mid_2   <= (PP_W+1)'(r_pp_hl_1) + (PP_W+1)'(r_pp_lh_1);
        r_top_2   <= {r_pp_hh_1, r_pp_ll_1[PP_W-1:HALF_W]};
        r_ul_2    <= r_ul_1;
        r_lo_2    <= r_lo_1;

        r_q_3     <= prod_top[DAY_K-HALF_W +: QUOT_W];
        r_ul_3    <= r_ul_2;
        r_lo_3    <= r_lo_2;

        r_qd_4    <= qd;
        r_q_4     <= r_q_3;
        r_ul_4    <= r_ul_3;
        r_lo_4    <= r_lo_3;

        r_rem_5   <= r_ul_4 - r_qd_4;
        r_q_5     <= r_q_4;
        r_lo_5    <= r_lo_4;
    end

    assign o_valid      = r_v[SPLIT_STAGES-1];
    assign o_split.quot = r_q_5;
    assign o_split.tod  = {r_rem_5, r_lo_5};

endmodule

### src/mcd_civil_date.sv
module mcd_civil_date (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [mcd_pkg::QUOT_W-1:0]  i_quot,
    output logic                        o_valid,
    output mcd_pkg::t_date              o_date
);
    import mcd_pkg::*;

    logic                  r_v [0:DATE_STAGES-1];

    logic [ZP_W-1:0]       r_zp_1, r_zp_2;
    logic [ERA_Q_W-1:0]    r_eq_2, r_eq_3, r_eq_4, r_eq_5, r_eq_6, r_eq_7, r_eq_8, r_eq_9;
    logic [DE_W-1:0]       r_de_3, r_de_4, r_de_5, r_de_6, r_de_7;
    logic [QA_W-1:0]       r_qa_4;
    logic [QB_W-1:0]       r_qb_4;
    logic                  r_qc_4;
    logic [DE_W-1:0]       r_t1_5;
    logic [YE_W-1:0]       r_ye_6, r_ye_7, r_ye_8, r_ye_9;
    logic [C100_W-1:0]     r_c_7;
    logic [DY_W-1:0]       r_dy_8, r_dy_9;
    logic [MP_W-1:0]       r_mp_9;
    t_date                 r_date_10;

    logic [QUOT_W-1:0]          zp_full;
    logic [ZP_W+ERA_M_W-1:0]    p_era;
    logic [ZP_W-1:0]            de_full;
    logic [36:0]                p_1460, p_36524, p_365;
    logic [18:0]                p_100;
    logic [DE_W-1:0]            yd;
    logic [DE_W-1:0]            dy_full;
    logic [X5_W-1:0]            x5;
    logic [22:0]                p_153;
    logic                       jan_feb;
    logic [MONTH_W-1:0]         n_month;
    logic [DY_W-1:0]            dd_full;
    logic [YEAR_W-1:0]          n_year;

    assign zp_full = i_quot + QUOT_W'(ZP_BIAS);
    assign p_era   = (ZP_W+ERA_M_W)'(r_zp_1) * (ZP_W+ERA_M_W)'(ERA_M);
    assign de_full = r_zp_2 - ZP_W'(r_eq_2) * ZP_W'(ERA_DAYS);
    assign p_1460  = 37'(r_de_3) * 37'(M1460);
    assign p_36524 = 37'(r_de_3) * 37'(M36524);
    assign p_365   = 37'(r_t1_5) * 37'(M365);
    assign p_100   = 19'(r_ye_6) * 19'(M100);
    assign yd      = DE_W'(r_ye_7) * YEAR_DAYS + DE_W'(r_ye_7[YE_W-1:2]) - DE_W'(r_c_7);
    assign dy_full = r_de_7 - yd;
    assign x5      = {r_dy_8, 2'b00} + X5_W'(r_dy_8) + X5_W'(2);
    assign p_153   = 23'(x5) * 23'(M153);

    // March-based month index: 10 and 11 are January and February
    assign jan_feb = r_mp_9 >= MP_JAN;
    assign n_month = jan_feb ? r_mp_9 - MONTH_W'(9) : r_mp_9 + MONTH_W'(3);
    assign dd_full = r_dy_9 - month_start(r_mp_9) + DY_W'(1);
    assign n_year  = YEAR_W'(r_ye_9) + YEAR_W'(r_eq_9) * YEAR_W'(ERA_YEARS)
                   - YEAR_BIAS + YEAR_W'(jan_feb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DATE_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DATE_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_zp_1 <= zp_full[ZP_W-1:0];

        r_zp_2 <= r_zp_1;
        r_eq_2 <= p_era[ERA_K+ERA_Q_W-1:ERA_K];

        r_de_3 <= de_full[DE_W-1:0];
        r_eq_3 <= r_eq_2;

        r_qa_4 <= p_1460[K1460+QA_W-1:K1460];
        r_qb_4 <= p_36524[K36524+QB_W-1:K36524];
        r_qc_4 <= r_de_3 == DE_LAST;
        r_de_4 <= r_de_3;
        r_eq_4 <= r_eq_3;

        r_t1_5 <= r_de_4 - DE_W'(r_qa_4) + DE_W'(r_qb_4) - DE_W'(r_qc_4);
        r_de_5 <= r_de_4;
        r_eq_5 <= r_eq_4;

        r_ye_6 <= p_365[K365+YE_W-1:K365];
        r_de_6 <= r_de_5;
        r_eq_6 <= r_eq_5;

        r_c_7  <= p_100[K100+C100_W-1:K100];
        r_ye_7 <= r_ye_6;
        r_de_7 <= r_de_6;
        r_eq_7 <= r_eq_6;

        r_dy_8 <= dy_full[DY_W-1:0];
        r_ye_8 <= r_ye_7;
        r_eq_8 <= r_eq_7;

        r_mp_9 <= p_153[K153+MP_W-1:K153];
        r_dy_9 <= r_dy_8;
        r_ye_9 <= r_ye_8;
        r_eq_9 <= r_eq_8;

        r_date_10.year  <= n_year;
        r_date_10.month <= n_month;
        r_date_10.day   <= dd_full[DAY_W-1:0];
    end

    assign o_valid = r_v[DATE_STAGES-1];
    assign o_date  = r_date_10;

endmodule

### src/mcd_time_of_day.sv
module mcd_time_of_day (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [mcd_pkg::TOD_W-1:0]  i_tod,
    output logic                       o_valid,
    output mcd_pkg::t_clock            o_clock
);
    import mcd_pkg::*;

    localparam int DEPTH = TIME_STAGES + TIME_PAD;

    logic                  r_v [0:DEPTH-1];

    logic [SX_W-1:0]       r_sx_1;
    logic [SECS_W-1:0]     r_secs_1, r_secs_2, r_secs_3;
    logic [USEC_SHIFT-1:0] r_lo_1;
    logic [USEC_W-1:0]     r_us_2, r_us_3, r_us_4, r_us_5;
    logic [HOUR_W-1:0]     r_hh_3, r_hh_4, r_hh_5;
    logic [RS_W-1:0]       r_rs_4, r_rs_5;
    logic [MIN_W-1:0]      r_mi_5;
    t_clock                r_clk_6;
    t_clock                r_pad [0:TIME_PAD-1];

    logic [SX_W-1:0]       sx;
    logic [62:0]           p_sec;
    logic [SX_W-1:0]       uh;
    logic [34:0]           p_hr;
    logic [SECS_W-1:0]     rs;
    logic [24:0]           p_min;
    logic [RS_W-1:0]       ss;

    assign sx    = i_tod[TOD_W-1:USEC_SHIFT];
    assign p_sec = 63'(sx) * 63'(M15625);
    assign uh    = r_sx_1 - SX_W'(r_secs_1) * SX_W'(USEC_DIV);
    assign p_hr  = 35'(r_secs_2) * 35'(M3600);
    assign rs    = r_secs_3 - SECS_W'(r_hh_3) * SECS_W'(HOUR_SECS);
    assign p_min = 25'(r_rs_4) * 25'(M60);
    assign ss    = r_rs_5 - RS_W'(r_mi_5) * RS_W'(MIN_SECS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx_1   <= sx;
        r_secs_1 <= p_sec[K15625+SECS_W-1:K15625];
        r_lo_1   <= i_tod[USEC_SHIFT-1:0];

        r_us_2   <= {uh[13:0], r_lo_1};
        r_secs_2 <= r_secs_1;

        r_hh_3   <= p_hr[K3600+HOUR_W-1:K3600];
        r_secs_3 <= r_secs_2;
        r_us_3   <= r_us_2;

        r_rs_4   <= rs[RS_W-1:0];
        r_hh_4   <= r_hh_3;
        r_us_4   <= r_us_3;

        r_mi_5   <= p_min[K60+MIN_W-1:K60];
        r_rs_5   <= r_rs_4;
        r_hh_5   <= r_hh_4;
        r_us_5   <= r_us_4;

        r_clk_6.hour   <= r_hh_5;
        r_clk_6.minute <= r_mi_5;
        r_clk_6.second <= ss[SEC_W-1:0];
        r_clk_6.usec   <= r_us_5;

        // delay to line up with the date path
        r_pad[0] <= r_clk_6;
        for (int k = 1; k < TIME_PAD; k++) begin
            r_pad[k] <= r_pad[k-1];
        end
    end

    assign o_valid = r_v[DEPTH-1];
    assign o_clock = r_pad[TIME_PAD-1];

endmodule

### src/micros_to_civil_datetime_core.sv
// Converts a signed 64-bit count of microseconds since 1970-01-01 00:00 UTC
// into proleptic Gregorian year, month, day, hour, minute, second and
// microsecond, with instants before the epoch landing on the earlier day.
// Fully pipelined: one beat can be started every cycle and busy stays low,
// so start alone launches a beat. Each result appears on the o_ field ports
// with o_valid high for one cycle, in order; the receiver must take it
// then. The pipeline is the day split, a reciprocal multiply by the day
// length in halves (6 stages), followed by the 10-stage calendar path. No
// state is kept between beats.
module micros_to_civil_datetime_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [mcd_pkg::MICROS_W-1:0]  i_micros,
    output logic                                 o_valid,
    output logic signed [mcd_pkg::YEAR_W-1:0]    o_year,
    output logic        [mcd_pkg::MONTH_W-1:0]   o_month,
    output logic        [mcd_pkg::DAY_W-1:0]     o_day,
    output logic        [mcd_pkg::HOUR_W-1:0]    o_hour,
    output logic        [mcd_pkg::MIN_W-1:0]     o_minute,
    output logic        [mcd_pkg::SEC_W-1:0]     o_second,
    output logic        [mcd_pkg::USEC_W-1:0]    o_microsecond
);
    import mcd_pkg::*;

    logic    split_valid;
    t_split  split;
    logic    date_valid;
    t_date   date;
    logic    time_valid;
    t_clock  clock;

    assign busy = 1'b0;

    mcd_day_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_micros (i_micros),
        .o_valid  (split_valid),
        .o_split  (split)
    );

    mcd_civil_date u_date (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (split_valid),
        .i_quot   (split.quot),
        .o_valid  (date_valid),
        .o_date   (date)
    );

    mcd_time_of_day u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (split_valid),
        .i_tod    (split.tod),
        .o_valid  (time_valid),
        .o_clock  (clock)
    );

    assign o_valid       = date_valid;
    assign o_year        = date.year;
    assign o_month       = date.month;
    assign o_day         = date.day;
    assign o_hour        = clock.hour;
    assign o_minute      = clock.minute;
    assign o_second      = clock.second;
    assign o_microsecond = clock.usec;

    a_paths_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        date_valid == time_valid)
        else $error("date and time-of-day paths out of step");

    a_start_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##PIPE_LAT o_valid)
        else $error("beat lost in pipeline");

    a_result_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, PIPE_LAT))
        else $error("result without a matching start");

    a_fields_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day >= 5'd1 &&
                     o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59 &&
                     o_microsecond <= 20'd999999))
        else $error("result field out of range");

endmodule
